/* rtl/csu_pkg.sv */
// Shared types and constants for the C string unescaper.
`timescale 1ns / 1ps

package csu_pkg;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_HEX0  = 2'd2,
    PH_HEX1  = 2'd3
  } phase_e;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;

  localparam logic [7:0] CTL_BEL = 8'd7;
  localparam logic [7:0] CTL_BS  = 8'd8;
  localparam logic [7:0] CTL_FF  = 8'd12;
  localparam logic [7:0] CTL_LF  = 8'd10;
  localparam logic [7:0] CTL_CR  = 8'd13;
  localparam logic [7:0] CTL_HT  = 8'd9;
  localparam logic [7:0] CTL_VT  = 8'd11;

  typedef struct packed {
    logic [1:0] n;
    logic [7:0] w0;
    logic [7:0] w1;
    phase_e     phase;
    logic [3:0] nibble;
  } dec_res_t;

endpackage

/* rtl/csu_decode.sv */
// Combinational escape decoder: one raw byte plus phase to up to two words.
`timescale 1ns / 1ps

module csu_decode (
  input  logic              id_mode_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  csu_pkg::phase_e   phase_i,
  input  logic [3:0]        nibble_i,
  output csu_pkg::dec_res_t res_o
);

  logic            hex_ok;
  logic [3:0]      hex_val;
  logic            plain_emit;
  logic [7:0]      plain_byte;
  csu_pkg::phase_e plain_phase;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      hex_val = 4'(byte_i - 8'h30);
    end else if (byte_i >= 8'h61 && byte_i <= 8'h66) begin
      hex_val = 4'(byte_i - 8'h57);
    end else if (byte_i >= 8'h41 && byte_i <= 8'h46) begin
      hex_val = 4'(byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    plain_byte  = byte_i;
    plain_emit  = 1'b1;
    plain_phase = csu_pkg::PH_PLAIN;
    if (byte_i == csu_pkg::CH_BSLASH && !last_i) begin
      plain_emit  = 1'b0;
      plain_phase = csu_pkg::PH_ESC;
    end
  end

  always_comb begin
    res_o.n      = 2'd0;
    res_o.w0     = 8'd0;
    res_o.w1     = byte_i;
    res_o.phase  = csu_pkg::PH_PLAIN;
    res_o.nibble = 4'd0;
    unique case (phase_i)
      csu_pkg::PH_PLAIN: begin
        res_o.n     = {1'b0, plain_emit};
        res_o.w0    = plain_byte;
        res_o.phase = plain_phase;
      end
      csu_pkg::PH_ESC: begin
        res_o.n = 2'd1;
        unique case (byte_i)
          csu_pkg::CH_SQUOTE, csu_pkg::CH_DQUOTE,
          csu_pkg::CH_QMARK, csu_pkg::CH_BSLASH: res_o.w0 = byte_i;
          csu_pkg::CH_A: res_o.w0 = csu_pkg::CTL_BEL;
          csu_pkg::CH_B: res_o.w0 = csu_pkg::CTL_BS;
          csu_pkg::CH_F: res_o.w0 = csu_pkg::CTL_FF;
          csu_pkg::CH_N: res_o.w0 = csu_pkg::CTL_LF;
          csu_pkg::CH_R: res_o.w0 = csu_pkg::CTL_CR;
          csu_pkg::CH_T: res_o.w0 = csu_pkg::CTL_HT;
          csu_pkg::CH_V: res_o.w0 = csu_pkg::CTL_VT;
          csu_pkg::CH_X: begin
            res_o.w0 = 8'd0;
            if (!last_i) begin
              res_o.n     = 2'd0;
              res_o.phase = csu_pkg::PH_HEX0;
            end
          end
          default: begin
            if (id_mode_i && (byte_i == csu_pkg::CH_DOT || byte_i == csu_pkg::CH_HASH)) begin
              res_o.w0 = byte_i;
            end else begin
              res_o.n  = 2'd2;
              res_o.w0 = csu_pkg::CH_BSLASH;
            end
          end
        endcase
      end
      csu_pkg::PH_HEX0: begin
        if (hex_ok) begin
          res_o.w0 = {4'd0, hex_val};
          if (last_i) begin
            res_o.n = 2'd1;
          end else begin
            res_o.phase  = csu_pkg::PH_HEX1;
            res_o.nibble = hex_val;
          end
        end else begin
          res_o.n     = 2'd1 + {1'b0, plain_emit};
          res_o.w0    = 8'd0;
          res_o.w1    = plain_byte;
          res_o.phase = plain_phase;
        end
      end
      csu_pkg::PH_HEX1: begin
        if (hex_ok) begin
          res_o.n  = 2'd1;
          res_o.w0 = {nibble_i, hex_val};
        end else begin
          res_o.n     = 2'd1 + {1'b0, plain_emit};
          res_o.w0    = {4'd0, nibble_i};
          res_o.w1    = plain_byte;
          res_o.phase = plain_phase;
        end
      end
      default: res_o.n = 2'd0;
    endcase
    if (last_i) begin
      res_o.phase  = csu_pkg::PH_PLAIN;
      res_o.nibble = 4'd0;
    end
  end

endmodule

/* rtl/csu_out_buf.sv */
// Two-word result buffer: takes one or two words, pops one a cycle on ready.
`timescale 1ns / 1ps

module csu_out_buf (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  logic [1:0] wr_n_i,
  input  logic [7:0] wr_w0_i,
  input  logic [7:0] wr_w1_i,
  input  logic       wr_last_i,
  output logic [1:0] free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] byte_out_o,
  output logic       last_out_o
);

  logic [1:0] cnt_q, cnt_d;
  logic [7:0] b0_q, b0_d, b1_q, b1_d;
  logic       l0_q, l0_d, l1_q, l1_d;
  logic       pop;
  logic [1:0] base;
  logic [7:0] sh0_b;
  logic       sh0_l;

  always_comb begin
    pop    = (cnt_q != 2'd0) && out_ready_i;
    base   = cnt_q - {1'b0, pop};
    free_o = 2'd2 - base;
    sh0_b  = pop ? b1_q : b0_q;
    sh0_l  = pop ? l1_q : l0_q;
    b0_d   = sh0_b;
    l0_d   = sh0_l;
    b1_d   = b1_q;
    l1_d   = l1_q;
    cnt_d  = base;
    if (wr_en_i) begin
      cnt_d = base + wr_n_i;
      if (base == 2'd0) begin
        b0_d = wr_w0_i;
        l0_d = wr_last_i && (wr_n_i == 2'd1);
        b1_d = wr_w1_i;
        l1_d = wr_last_i;
      end else if (base == 2'd1) begin
        b1_d = wr_w0_i;
        l1_d = wr_last_i && (wr_n_i == 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q <= b0_d;
    b1_q <= b1_d;
    l0_q <= l0_d;
    l1_q <= l1_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign byte_out_o  = b0_q;
  assign last_out_o  = l0_q;

endmodule

/* rtl/c_string_unescaper_unit.sv */
// Streaming C escaped-string decoder, one raw byte per word in.
// An accepted word is registered, decoded, then written to the output buffer.
// Throughput: one input word per cycle while the buffer has room; an item giving
// two words can hold the input, bounded by the buffer's single output port.
// Reset: asynchronous active low; clears phase, hex digit, id_mode and valids.
`timescale 1ns / 1ps

module c_string_unescaper_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  input  logic       last_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] byte_out_o,
  output logic       last_out_o
);

  logic              id_mode_q;
  logic              s1_valid_q;
  logic [7:0]        s1_byte_q;
  logic              s1_last_q;
  csu_pkg::phase_e   phase_q;
  logic [3:0]        nibble_q;
  csu_pkg::dec_res_t dec;
  logic [1:0]        free;
  logic              move;
  logic              accept;

  csu_decode u_decode (
    .id_mode_i (id_mode_q),
    .byte_i    (s1_byte_q),
    .last_i    (s1_last_q),
    .phase_i   (phase_q),
    .nibble_i  (nibble_q),
    .res_o     (dec)
  );

  assign move       = s1_valid_q && (dec.n <= free);
  assign in_ready_o = !s1_valid_q || move;
  assign accept     = in_valid_i && in_ready_o;

  csu_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (move),
    .wr_n_i      (dec.n),
    .wr_w0_i     (dec.w0),
    .wr_w1_i     (dec.w1),
    .wr_last_i   (s1_last_q),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .byte_out_o  (byte_out_o),
    .last_out_o  (last_out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_mode_q  <= 1'b0;
      s1_valid_q <= 1'b0;
      phase_q    <= csu_pkg::PH_PLAIN;
      nibble_q   <= 4'd0;
    end else begin
      if (cfg_we_i) begin
        id_mode_q <= cfg_data_i;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (move) begin
        s1_valid_q <= 1'b0;
      end
      if (move) begin
        phase_q  <= dec.phase;
        nibble_q <= dec.nibble;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= byte_in_i;
      s1_last_q <= last_in_i;
    end
  end

endmodule
